FILE: rtl/cmbd_pkg.sv
// shared types and constants for the capacitance matrix baseline/delta block
// no dependencies; imported by every module of the block
`default_nettype none

package cmbd_pkg;

	// fixed field widths
	localparam int CODE_W     = 28;
	localparam int SQ_W       = 2 * CODE_W;
	localparam int SCALE_W    = 63;
	localparam int AVG_W      = 5;
	localparam int CAP_W      = 31;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = 4;
	localparam int PIX_W      = 2 * IDX_W;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 40;
	localparam int CFG_ADDR_W = 1;

	// divider geometry
	localparam int DIVIDEND_W = SCALE_W;
	localparam int DIVISOR_W  = SQ_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// parameter defaults
	localparam int ROW_COUNT_DEF   = 16;
	localparam int COL_COUNT_DEF   = 16;
	localparam int MAX_AVERAGE_DEF = 16;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RESET = 63'd3456920000000000000;
	localparam logic [AVG_W-1:0]   AVG_RESET   = 5'd12;
	localparam logic [CAP_W-1:0]   CAP_MAX     = {CAP_W{1'b1}};

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_CAP_SCALE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_AVG_COUNT = 1'b1;

	// input op and result kind codes
	localparam logic OP_BASELINE   = 1'b0;
	localparam logic OP_SCAN       = 1'b1;
	localparam logic KIND_BASELINE = 1'b0;
	localparam logic KIND_DELTA    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CAP_START,
		ST_CAP_DIV,
		ST_APPLY,
		ST_AVG_START,
		ST_AVG_DIV,
		ST_OUT
	} cmbd_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} cmbd_mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/cap_matrix_baseline_delta.sv
// top level: sequencer, squaring, baseline averaging and result register
// depends on cmbd_pkg, cmbd_divider and cmbd_store
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser op, tdata row, col, code
//  m_*      | out       | m_tvalid/m_tready  | tuser kind, tdata out_row, out_col, value
//  cfg_*    | in        | cfg_we             | cfg_addr index, cfg_wdata value
//
// a scan sample steps through MUL, CAP_START, CAP_DIV, APPLY and OUT, its division done by
// the 63-step shared divider, and raises m_tvalid when OUT loads the result register,
// which waits while an earlier result is still held; the next transfer is taken once the
// sequencer is back in idle. a baseline sample that leaves its group open gives no result;
// a sample that closes a group runs the divider a second time for the average.
// a zero code skips the first division. ready is high only while idle.
// reset clears the baseline store at once through per-entry valid bits, no sweep.
// a result waiting on m_tready does not block the next input transfer.
`default_nettype none

module cap_matrix_baseline_delta #(
	parameter int ROW_COUNT   = cmbd_pkg::ROW_COUNT_DEF,
	parameter int COL_COUNT   = cmbd_pkg::COL_COUNT_DEF,
	parameter int MAX_AVERAGE = cmbd_pkg::MAX_AVERAGE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// row[3:0], col[7:4], code[35:8], zero pad
	input  wire logic [cmbd_pkg::S_TDATA_W-1:0]  s_tdata,
	// op
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_row[3:0], out_col[7:4], value[39:8]
	output logic      [cmbd_pkg::M_TDATA_W-1:0]  m_tdata,
	// kind
	output logic                                 m_tuser,
	input  wire logic                            cfg_we,
	input  wire logic [cmbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [cmbd_pkg::SCALE_W-1:0]    cfg_wdata
);
	import cmbd_pkg::*;

	localparam int STORE_DEPTH = ROW_COUNT * 16;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_AVERAGE + 1);
	localparam int SUM_W       = CAP_W + $clog2(MAX_AVERAGE);
	localparam int CMP_W       = 8;

	cmbd_state_t state_q, state_nx;

	// configuration
	logic [SCALE_W-1:0] cap_scale_q;
	logic [AVG_W-1:0]   avg_count_q;

	// item and working registers
	logic               op_q;
	logic [IDX_W-1:0]   row_q;
	logic [IDX_W-1:0]   col_q;
	logic [CODE_W-1:0]  code_q;
	logic [SQ_W-1:0]    sq_q;
	logic [CAP_W-1:0]   cap_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   tally_q;
	logic [PIX_W-1:0]   held_q;
	logic               res_kind_q;
	logic [VALUE_W-1:0] res_value_q;

	// result register
	logic               m_tvalid_q;
	logic               out_kind_q;
	logic [IDX_W-1:0]   out_row_q;
	logic [IDX_W-1:0]   out_col_q;
	logic [VALUE_W-1:0] out_value_q;

	logic [IDX_W-1:0]      in_row;
	logic [IDX_W-1:0]      in_col;
	logic [CODE_W-1:0]     in_code;
	logic                  in_range;
	logic                  in_xfer;
	logic                  out_free;
	logic                  out_load;
	logic [PIX_W-1:0]      pix;
	logic [CNT_W-1:0]      eff_n;
	logic                  new_group;
	logic [SUM_W-1:0]      sum_nx;
	logic [CNT_W-1:0]      tally_nx;
	logic                  group_full;
	logic [CAP_W-1:0]      cap_div;
	logic [VALUE_W-1:0]    delta;
	logic [VALUE_W-1:0]    avg;

	logic                  div_start;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic [DIVIDEND_W-1:0] div_quotient;

	cmbd_mem_req_t         mem_req;
	logic [VALUE_W-1:0]    base_rd;

	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
	assign in_code  = s_tdata[2*IDX_W+CODE_W-1:2*IDX_W];
	assign in_range = (CMP_W'(in_row) < CMP_W'(ROW_COUNT)) &&
	                  (CMP_W'(in_col) < CMP_W'(COL_COUNT));
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign pix      = {row_q, col_q};

	// avg_count of zero counts as one, above the limit counts as the limit
	always_comb begin
		if (avg_count_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (CMP_W'(avg_count_q) > CMP_W'(MAX_AVERAGE)) begin
			eff_n = CNT_W'(MAX_AVERAGE);
		end else begin
			eff_n = CNT_W'(avg_count_q);
		end
	end

	assign new_group  = (tally_q == '0) || (held_q != pix);
	assign sum_nx     = new_group ? SUM_W'(cap_q) : sum_q + SUM_W'(cap_q);
	assign tally_nx   = new_group ? CNT_W'(1) : tally_q + 1'b1;
	assign group_full = tally_nx >= eff_n;

	assign cap_div = (div_quotient[DIVIDEND_W-1:CAP_W] != '0) ? CAP_MAX
	                                                           : div_quotient[CAP_W-1:0];
	assign delta   = {1'b0, cap_q} - base_rd;
	assign avg     = div_quotient[VALUE_W-1:0];

	assign div_dividend = (state_q == ST_AVG_START) ? DIVIDEND_W'(sum_q) : cap_scale_q;
	assign div_divisor  = (state_q == ST_AVG_START) ? DIVISOR_W'(eff_n) : sq_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && in_range) state_nx = ST_MUL;
			end
			ST_MUL: begin
				state_nx = (code_q == '0) ? ST_APPLY : ST_CAP_START;
			end
			ST_CAP_START: state_nx = ST_CAP_DIV;
			ST_CAP_DIV: begin
				if (div_done) state_nx = ST_APPLY;
			end
			ST_APPLY: begin
				if (op_q == OP_SCAN) state_nx = ST_OUT;
				else if (group_full) state_nx = ST_AVG_START;
				else state_nx = ST_IDLE;
			end
			ST_AVG_START: state_nx = ST_AVG_DIV;
			ST_AVG_DIV: begin
				if (div_done) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready      = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		mem_req.rd_en = 1'b0;
		mem_req.wr_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				mem_req.rd_en = s_tvalid;
			end
			ST_CAP_START: div_start = 1'b1;
			ST_AVG_START: div_start = 1'b1;
			ST_AVG_DIV:   mem_req.wr_en = div_done;
			ST_OUT:       out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_scale_q <= SCALE_RESET;
			avg_count_q <= AVG_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CAP_SCALE: cap_scale_q <= cfg_wdata;
				CFG_AVG_COUNT: avg_count_q <= cfg_wdata[AVG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// baseline group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			tally_q <= '0;
			held_q  <= '0;
		end else if (state_q == ST_APPLY) begin
			if (op_q == OP_SCAN || group_full) begin
				sum_q   <= (op_q == OP_SCAN) ? '0 : sum_nx;
				tally_q <= '0;
				if (op_q != OP_SCAN) held_q <= pix;
			end else begin
				sum_q   <= sum_nx;
				tally_q <= tally_nx;
				held_q  <= pix;
			end
		end else if (state_q == ST_AVG_DIV && div_done) begin
			sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q   <= s_tuser;
			row_q  <= in_row;
			col_q  <= in_col;
			code_q <= in_code;
		end
		if (state_q == ST_MUL) begin
			sq_q <= SQ_W'(code_q) * SQ_W'(code_q);
			if (code_q == '0) cap_q <= CAP_MAX;
		end
		if (state_q == ST_CAP_DIV && div_done) begin
			cap_q <= cap_div;
		end
		if (state_q == ST_APPLY && op_q == OP_SCAN) begin
			res_kind_q  <= KIND_DELTA;
			res_value_q <= delta;
		end
		if (state_q == ST_AVG_DIV && div_done) begin
			res_kind_q  <= KIND_BASELINE;
			res_value_q <= avg;
		end
		if (out_load) begin
			out_kind_q  <= res_kind_q;
			out_row_q   <= row_q;
			out_col_q   <= col_q;
			out_value_q <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	cmbd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	cmbd_store #(
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_addr (ADDR_W'({in_row, in_col})),
		.wr_addr (ADDR_W'(pix)),
		.wr_data (avg),
		.rd_data (base_rd)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {out_value_q, out_col_q, out_row_q};

endmodule

`default_nettype wire

FILE: rtl/cmbd_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on cmbd_pkg for operand widths
`default_nettype none

module cmbd_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [cmbd_pkg::DIVIDEND_W-1:0] dividend,
	input  wire logic [cmbd_pkg::DIVISOR_W-1:0]  divisor,
	output logic                                 done,
	output logic      [cmbd_pkg::DIVIDEND_W-1:0] quotient
);
	import cmbd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign shifted = {rem_q, dq_q[DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			dq_q      <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

FILE: rtl/cmbd_store.sv
// per-pixel baseline memory with registered read; entries never written read as zero
// depends on cmbd_pkg for the request struct and value width
`default_nettype none

module cmbd_store #(
	parameter int DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cmbd_pkg::cmbd_mem_req_t      req,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic [cmbd_pkg::VALUE_W-1:0] wr_data,
	output logic      [cmbd_pkg::VALUE_W-1:0] rd_data
);
	import cmbd_pkg::*;

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire
